>>> hw/rtl/ilst_pkg.sv
package ilst_pkg;

   localparam int CAPACITY   = 16;
   localparam int WORD_WIDTH = 32;

   // Fixed field widths of the request and response.
   localparam int KIND_W   = 2;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] req_type;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] item_word;
   } ilst_req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   removed_word;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } ilst_rsp_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic                  insert;
      logic                  remove;
      logic [CMP_W-1:0]      position;
      logic [WORD_WIDTH-1:0] word;
   } ilst_ctrl_type;

endpackage

>>> hw/rtl/ilst_cell.sv
module ilst_cell
   import ilst_pkg::*;
(
   input  logic                  clock,
   input  logic [IDX_W-1:0]      cell_index,
   input  ilst_ctrl_type         ctrl,
   input  logic [WORD_WIDTH-1:0] left_word,
   input  logic [WORD_WIDTH-1:0] right_word,
   output logic [WORD_WIDTH-1:0] word
);

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;
   logic [CMP_W-1:0]      index;

   assign index = CMP_W'(cell_index);

   always_comb begin
      word_in = word_ff;
      if (ctrl.insert) begin
         if (index > ctrl.position) begin
            word_in = left_word;
         end else if (index == ctrl.position) begin
            word_in = ctrl.word;
         end
      end else if (ctrl.remove) begin
         // close the gap: everything at or above the removed slot moves down
         if (index >= ctrl.position) begin
            word_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

>>> hw/rtl/indexed_insert_remove_list_core.sv
// Ordered list of up to CAPACITY words held in a chain of cells, one word per
// cell. On append, insert-at-position and remove-at-position, every cell at or
// above the position moves its word to a neighbor in the same clock, so one
// request is accepted per cycle while the response register is free or drained.
// Each request returns exactly one response with the removed word (zero unless
// a remove succeeded), a status (ok, full, out of range, empty) and the count
// after the request. No clearing pass is needed after reset; cells at or above
// the count are never read.
module indexed_insert_remove_list_core
   import ilst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ilst_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ilst_rsp_type rsp_payload
);

   logic [FILL_W-1:0]     fill_ff;
   logic [FILL_W-1:0]     fill_in;
   logic                  rsp_valid_ff;
   ilst_rsp_type          rsp_ff;
   ilst_rsp_type          rsp_in;
   ilst_ctrl_type         ctrl;
   logic                  accept;
   logic [CMP_W-1:0]      fill_cmp;
   logic [CMP_W-1:0]      ins_pos;
   logic                  full;
   logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
   logic [WORD_WIDTH-1:0] taken_word;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign fill_cmp  = CMP_W'(fill_ff);
   assign full      = (fill_ff == FILL_W'(CAPACITY));
   assign ins_pos   = (req_payload.req_type == KIND_APPEND) ?
                      fill_cmp : CMP_W'(req_payload.position);
   assign taken_word = cell_word[IDX_W'(req_payload.position)];

   always_comb begin
      ctrl.insert   = 1'b0;
      ctrl.remove   = 1'b0;
      ctrl.position = ins_pos;
      ctrl.word     = WORD_WIDTH'(req_payload.item_word);
      fill_in       = fill_ff;
      rsp_in.removed_word = '0;
      rsp_in.status       = STATUS_OK;
      case (req_payload.req_type)
         KIND_APPEND, KIND_INSERT: begin
            if (full) begin
               rsp_in.status = STATUS_FULL;
            end else if (ins_pos > fill_cmp) begin
               rsp_in.status = STATUS_RANGE;
            end else begin
               ctrl.insert = accept;
               fill_in     = fill_ff + FILL_W'(1);
            end
         end
         KIND_REMOVE: begin
            if (fill_ff == '0) begin
               rsp_in.status = STATUS_EMPTY;
            end else if (ins_pos >= fill_cmp) begin
               rsp_in.status = STATUS_RANGE;
            end else begin
               ctrl.remove         = accept;
               fill_in             = fill_ff - FILL_W'(1);
               rsp_in.removed_word = DATA_W'(taken_word);
            end
         end
         default: begin
            // unused kind: no change, ok status
         end
      endcase
      rsp_in.count = COUNT_W'(fill_in);
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_word;
      logic [WORD_WIDTH-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_mid_l
         assign left_word = cell_word[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_mid_r
         assign right_word = cell_word[i+1];
      end

      ilst_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .ctrl       (ctrl),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff      <= fill_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the response until its transfer completes
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> tb/ilst_checker.sv
`timescale 1ns / 100ps

module ilst_checker
   import ilst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  ilst_req_type req_payload,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  ilst_rsp_type rsp_payload,
   output int           fail_count,
   output int           pending,
   output int           list_fill
);

   logic [WORD_WIDTH-1:0] list_words [CAPACITY];
   int                    fill_level;
   ilst_rsp_type          expected_replies [$];

   assign pending   = expected_replies.size();
   assign list_fill = fill_level;

   // Apply one request to the shadow list and return the reply it should produce.
   function automatic ilst_rsp_type apply_list_request(input ilst_req_type req);
      ilst_rsp_type reply;
      int           slot;
      int           i;
      reply = '0;
      slot  = req.position;
      case (req.req_type)
         KIND_APPEND, KIND_INSERT: begin
            if (req.req_type == KIND_APPEND) slot = fill_level;
            // full is checked before the position
            if (fill_level >= CAPACITY) begin
               reply.status = STATUS_FULL;
            end else if (slot > fill_level) begin
               reply.status = STATUS_RANGE;
            end else begin
               for (i = fill_level; i > slot; i--) list_words[i] = list_words[i-1];
               list_words[slot] = req.item_word[WORD_WIDTH-1:0];
               fill_level++;
               reply.status = STATUS_OK;
            end
         end
         KIND_REMOVE: begin
            if (fill_level == 0) begin
               reply.status = STATUS_EMPTY;
            end else if (slot >= fill_level) begin
               reply.status = STATUS_RANGE;
            end else begin
               reply.removed_word = DATA_W'(list_words[slot]);
               for (i = slot; i + 1 < fill_level; i++) list_words[i] = list_words[i+1];
               fill_level--;
               reply.status = STATUS_OK;
            end
         end
         default: begin
            // unused kind: no change, status ok
            reply.status = STATUS_OK;
         end
      endcase
      reply.count = COUNT_W'(fill_level);
      return reply;
   endfunction

   always @(posedge clock) begin
      ilst_rsp_type want;
      if (reset) begin
         fill_level = 0;
         fail_count = 0;
         expected_replies.delete();
      end else begin
         if (req_valid && req_ready) expected_replies.push_back(apply_list_request(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected response word %h status %0d count %0d", $realtime,
                           rsp_payload.removed_word, rsp_payload.status, rsp_payload.count);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_payload.removed_word !== want.removed_word
                   || rsp_payload.status !== want.status
                   || rsp_payload.count !== want.count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch: expected word %h status %0d count %0d,",
                               " got word %h status %0d count %0d"},
                              $realtime, want.removed_word, want.status, want.count,
                              rsp_payload.removed_word, rsp_payload.status, rsp_payload.count);
               end
            end
         end
      end
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import ilst_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int QUIET_LIMIT  = 5000;
   localparam int PHASE_ITEMS  = 150;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   ilst_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_ready;
   ilst_rsp_type rsp_payload;

   int fail_count;
   int pending;
   int list_fill;
   int idle_pct;
   int stall_pct;
   int quiet_cycles;
   bit growing;

   indexed_insert_remove_list_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   ilst_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending),
      .list_fill   (list_fill)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // End the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL indexed_insert_remove_list_core");
            $finish;
         end
      end
   end

   function automatic ilst_req_type make_req(input logic [KIND_W-1:0] kind,
                                             input logic [POS_W-1:0] pos,
                                             input logic [DATA_W-1:0] word);
      ilst_req_type item;
      item.req_type  = kind;
      item.position  = pos;
      item.item_word = word;
      return item;
   endfunction

   // Hold valid through the transfer; leave it high for the caller.
   task automatic send_request(input ilst_req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly well-formed adds and removes that sweep the fill between empty and full.
   task automatic pick_random_item(output ilst_req_type item);
      int roll;
      int fill_now;
      fill_now = list_fill;
      roll     = $urandom_range(0, 99);
      if (fill_now >= CAPACITY) growing = 1'b0;
      else if (fill_now == 0) growing = 1'b1;
      else if ($urandom_range(0, 39) == 0) growing = !growing;
      item.item_word = $urandom;
      if ($urandom_range(0, 9) == 0) item.item_word = $urandom_range(0, 1) ? '0 : '1;
      item.position = POS_W'($urandom);
      if (roll < 8) begin
         // noise: any kind, positions at or past the end
         item.req_type = KIND_W'($urandom_range(0, 3));
         item.position = POS_W'($urandom_range(fill_now, 31));
      end else if (roll < (growing ? 72 : 28)) begin
         if ($urandom_range(0, 2) == 0) begin
            item.req_type = KIND_APPEND;
         end else begin
            item.req_type = KIND_INSERT;
            item.position = POS_W'($urandom_range(0, fill_now));
         end
      end else begin
         item.req_type = KIND_REMOVE;
         if (fill_now > 0) item.position = POS_W'($urandom_range(0, fill_now - 1));
      end
   endtask

   initial begin
      ilst_req_type item;
      int           sent;
      int           phase;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      idle_pct    = 0;
      stall_pct   = 0;
      growing     = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(make_req(KIND_REMOVE, 5'd0, 32'h0));           // remove from empty
      send_request(make_req(KIND_UNUSED, 5'd31, 32'hFFFF_FFFF));  // unused kind
      send_request(make_req(KIND_APPEND, 5'd31, 32'h0000_0000));
      send_request(make_req(KIND_APPEND, 5'd0, 32'hFFFF_FFFF));
      send_request(make_req(KIND_INSERT, 5'd0, 32'hA5A5_A5A5));   // insert at head
      send_request(make_req(KIND_INSERT, 5'd3, 32'h5A5A_5A5A));   // insert at end
      send_request(make_req(KIND_INSERT, 5'd5, 32'h1234_5678));   // past the end
      send_request(make_req(KIND_INSERT, 5'd31, 32'h8765_4321));
      send_request(make_req(KIND_REMOVE, 5'd4, 32'h0));           // remove at count
      send_request(make_req(KIND_REMOVE, 5'd31, 32'h0));
      send_request(make_req(KIND_REMOVE, 5'd0, 32'h0));
      send_request(make_req(KIND_REMOVE, 5'd2, 32'h0));           // remove last
      send_request(make_req(KIND_INSERT, 5'd1, 32'hDEAD_BEEF));   // insert in the middle
      while (list_fill < CAPACITY)
         send_request(make_req(KIND_INSERT, POS_W'($urandom_range(0, list_fill)), $urandom));
      send_request(make_req(KIND_APPEND, 5'd0, 32'hFFFF_FFFF));   // full
      send_request(make_req(KIND_INSERT, 5'd31, 32'h0));          // full beats range
      send_request(make_req(KIND_REMOVE, 5'd15, 32'h0));

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick_random_item(item);
            send_request(item);
            if (item.req_type != KIND_UNUSED) sent++;
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS indexed_insert_remove_list_core");
      end else begin
         $display("FAIL indexed_insert_remove_list_core");
      end
      $finish;
   end

endmodule

>>> indexed_insert_remove_list_core.f
hw/rtl/ilst_pkg.sv
hw/rtl/ilst_cell.sv
hw/rtl/indexed_insert_remove_list_core.sv
tb/ilst_checker.sv
tb/tb_top.sv
